### sv/v3norm_pkg.sv
// ----------------------------------------------------------------------------
// v3norm_pkg
// Shared constants for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package v3norm_pkg;
	localparam int COORD_BITS_DEF     = 16;
	localparam int UNIT_FRAC_BITS_DEF = 14;
	localparam int FIFO_DEPTH         = 4;
	localparam int NUM_AXES           = 3;
endpackage

### sv/v3norm_front.sv
// ----------------------------------------------------------------------------
// v3norm_front
// Difference, magnitude, squares and sum of squares, four stages.
// ----------------------------------------------------------------------------
module v3norm_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [COORD_BITS-1:0]           start_x,
	input  logic [COORD_BITS-1:0]           start_y,
	input  logic [COORD_BITS-1:0]           start_z,
	input  logic [COORD_BITS-1:0]           end_x,
	input  logic [COORD_BITS-1:0]           end_y,
	input  logic [COORD_BITS-1:0]           end_z,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic [2:0][COORD_BITS-1:0]      push_mag,
	output logic [2:0]                      push_neg,
	output logic [2*COORD_BITS+1:0]         push_sum
);
	import v3norm_pkg::*;

	localparam int CB = COORD_BITS;

	logic                  en;
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [2:0][CB:0]      d_s1;
	logic [2:0][CB-1:0]    mag_s2, mag_s3, mag_s4;
	logic [2:0]            neg_s2, neg_s3, neg_s4;
	logic [2:0][2*CB-1:0]  sq_s3;
	logic [2*CB+1:0]       sum_s4;
	logic [2:0][CB-1:0]    st, en_pt;
	logic [2:0][CB:0]      d_abs;

	assign en       = !v_s4 || push_ready;
	assign in_ready = en;

	assign st    = {start_z, start_y, start_x};
	assign en_pt = {end_z, end_y, end_x};

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			d_abs[i] = d_s1[i][CB] ? (~d_s1[i] + 1'b1) : d_s1[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				d_s1[i]   <= {en_pt[i][CB-1], en_pt[i]} - {st[i][CB-1], st[i]};
				mag_s2[i] <= d_abs[i][CB-1:0];
				neg_s2[i] <= d_s1[i][CB];
				mag_s3[i] <= mag_s2[i];
				neg_s3[i] <= neg_s2[i];
				sq_s3[i]  <= mag_s2[i] * mag_s2[i];
				mag_s4[i] <= mag_s3[i];
				neg_s4[i] <= neg_s3[i];
			end
			sum_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
		end
	end

	assign push_valid = v_s4;
	assign push_mag   = mag_s4;
	assign push_neg   = neg_s4;
	assign push_sum   = sum_s4;
endmodule

### sv/v3norm_fifo.sv
// ----------------------------------------------------------------------------
// v3norm_fifo
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module v3norm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	import v3norm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule

### sv/v3norm_back.sv
// ----------------------------------------------------------------------------
// v3norm_back
// Pipelined square root (one result bit per stage) followed by three
// pipelined dividers (one quotient bit per stage); last stage is the output.
// ----------------------------------------------------------------------------
module v3norm_back #(
	parameter int COORD_BITS     = 16,
	parameter int UNIT_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0][COORD_BITS-1:0]        in_mag,
	input  logic [2:0]                        in_neg,
	input  logic [2*COORD_BITS+1:0]           in_sum,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [UNIT_FRAC_BITS+1:0]  norm_x,
	output logic signed [UNIT_FRAC_BITS+1:0]  norm_y,
	output logic signed [UNIT_FRAC_BITS+1:0]  norm_z,
	output logic [COORD_BITS:0]               vec_length,
	output logic                              zero_length
);
	import v3norm_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int LW = CB + 1;
	localparam int RW = LW + 3;
	localparam int NS = LW;
	localparam int ND = UNIT_FRAC_BITS + 1;
	localparam int QW = UNIT_FRAC_BITS + 1;
	localparam int NW = UNIT_FRAC_BITS + 2;

	logic adv;

	// square root pipeline registers, index = steps done
	logic [NS:1]                 sq_v;
	logic [NS:1][2*LW-1:0]       sq_n;
	logic [NS:1][RW-1:0]         sq_rem;
	logic [NS:1][LW-1:0]         sq_res;
	logic [NS:1][2:0][CB-1:0]    sq_mag;
	logic [NS:1][2:0]            sq_neg;

	logic [NS-1:0]               ss_v;
	logic [NS-1:0][2*LW-1:0]     ss_n;
	logic [NS-1:0][RW-1:0]       ss_rem;
	logic [NS-1:0][LW-1:0]       ss_res;
	logic [NS-1:0][2:0][CB-1:0]  ss_mag;
	logic [NS-1:0][2:0]          ss_neg;
	logic [NS-1:0][RW-1:0]       sn_rem;
	logic [NS-1:0][LW-1:0]       sn_res;

	// divider pipeline registers
	logic [ND:1]                 dv_v;
	logic [ND:1][2:0][LW-1:0]    dv_r;
	logic [ND:1][2:0][QW-1:0]    dv_q;
	logic [ND:1][LW-1:0]         dv_len;
	logic [ND:1][2:0]            dv_neg;

	logic [ND-1:0]               ds_v;
	logic [ND-1:0][2:0][LW-1:0]  ds_r;
	logic [ND-1:0][2:0][QW-1:0]  ds_q;
	logic [ND-1:0][LW-1:0]       ds_len;
	logic [ND-1:0][2:0]          ds_neg;
	logic [ND-1:0][2:0][LW-1:0]  dn_r;
	logic [ND-1:0][2:0][QW-1:0]  dn_q;

	logic [2:0][NW-1:0]          norm_c;

	assign out_valid = dv_v[ND];
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;

	always_comb begin
		logic [RW-1:0] t;
		logic [RW-1:0] trial;
		ss_v[0]   = in_valid;
		ss_n[0]   = in_sum;
		ss_rem[0] = '0;
		ss_res[0] = '0;
		ss_mag[0] = in_mag;
		ss_neg[0] = in_neg;
		for (int s = 1; s < NS; s++) begin
			ss_v[s]   = sq_v[s];
			ss_n[s]   = sq_n[s];
			ss_rem[s] = sq_rem[s];
			ss_res[s] = sq_res[s];
			ss_mag[s] = sq_mag[s];
			ss_neg[s] = sq_neg[s];
		end
		for (int s = 0; s < NS; s++) begin
			t     = {ss_rem[s][RW-3:0], ss_n[s][2*LW-1 -: 2]};
			trial = {{(RW-LW-2){1'b0}}, ss_res[s], 2'b01};
			if (t >= trial) begin
				sn_rem[s] = t - trial;
				sn_res[s] = {ss_res[s][LW-2:0], 1'b1};
			end else begin
				sn_rem[s] = t;
				sn_res[s] = {ss_res[s][LW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		logic [LW:0] t;
		logic        bin;
		ds_v[0]   = sq_v[NS];
		ds_len[0] = sq_res[NS];
		ds_neg[0] = sq_neg[NS];
		for (int i = 0; i < NUM_AXES; i++) begin
			ds_r[0][i] = LW'(sq_mag[NS][i] >> 1);
			ds_q[0][i] = '0;
		end
		for (int j = 1; j < ND; j++) begin
			ds_v[j]   = dv_v[j];
			ds_r[j]   = dv_r[j];
			ds_q[j]   = dv_q[j];
			ds_len[j] = dv_len[j];
			ds_neg[j] = dv_neg[j];
		end
		for (int j = 0; j < ND; j++) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				bin = (j == 0) ? sq_mag[NS][i][0] : 1'b0;
				t   = {ds_r[j][i], bin};
				if (t >= {1'b0, ds_len[j]}) begin
					dn_r[j][i] = LW'(t - {1'b0, ds_len[j]});
					dn_q[j][i] = {ds_q[j][i][QW-2:0], 1'b1};
				end else begin
					dn_r[j][i] = t[LW-1:0];
					dn_q[j][i] = {ds_q[j][i][QW-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v <= '0;
			dv_v <= '0;
		end else if (adv) begin
			for (int s = 0; s < NS; s++) begin
				sq_v[s+1] <= ss_v[s];
			end
			for (int j = 0; j < ND; j++) begin
				dv_v[j+1] <= ds_v[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = 0; s < NS; s++) begin
				sq_n[s+1]   <= ss_n[s] << 2;
				sq_rem[s+1] <= sn_rem[s];
				sq_res[s+1] <= sn_res[s];
				sq_mag[s+1] <= ss_mag[s];
				sq_neg[s+1] <= ss_neg[s];
			end
			for (int j = 0; j < ND; j++) begin
				dv_r[j+1]   <= dn_r[j];
				dv_q[j+1]   <= dn_q[j];
				dv_len[j+1] <= ds_len[j];
				dv_neg[j+1] <= ds_neg[j];
			end
		end
	end

	assign zero_length = (dv_len[ND] == '0);
	assign vec_length  = dv_len[ND];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			if (zero_length) begin
				norm_c[i] = '0;
			end else if (dv_neg[ND][i]) begin
				norm_c[i] = ~{1'b0, dv_q[ND][i]} + 1'b1;
			end else begin
				norm_c[i] = {1'b0, dv_q[ND][i]};
			end
		end
	end

	assign norm_x = norm_c[0];
	assign norm_y = norm_c[1];
	assign norm_z = norm_c[2];
endmodule

### sv/vector3_normalizer_core.sv
// ----------------------------------------------------------------------------
// vector3_normalizer_core
// Difference vector of two Q8.8 points, its length and its Q1.14 unit vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request: two points
//   (start_*, end_*). Output channel out_valid/out_ready returns one result
//   per request, in order: norm_x/y/z (Q1.14), vec_length (Q9.8) and
//   zero_length, which is set with all other outputs zero when the points
//   coincide.
//   Throughput: one request per cycle when the receiver keeps out_ready high.
//   A request passes 4 front stages, the queue, (COORD_BITS+1) root
//   stages and (UNIT_FRAC_BITS+1) divide stages. The root and divider
//   pipelines retire one bit per stage. The front and back each stall on
//   their own; the 4-entry queue between them absorbs short back-end
//   stalls. A stalled receiver freezes the back pipeline, fills the queue,
//   then drops in_ready.
//   Reset (arst_n low) empties every stage and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module vector3_normalizer_core #(
	parameter int COORD_BITS     = v3norm_pkg::COORD_BITS_DEF,
	parameter int UNIT_FRAC_BITS = v3norm_pkg::UNIT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_BITS-1:0]      start_x,
	input  logic signed [COORD_BITS-1:0]      start_y,
	input  logic signed [COORD_BITS-1:0]      start_z,
	input  logic signed [COORD_BITS-1:0]      end_x,
	input  logic signed [COORD_BITS-1:0]      end_y,
	input  logic signed [COORD_BITS-1:0]      end_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [UNIT_FRAC_BITS+1:0]  norm_x,
	output logic signed [UNIT_FRAC_BITS+1:0]  norm_y,
	output logic signed [UNIT_FRAC_BITS+1:0]  norm_z,
	output logic [COORD_BITS:0]               vec_length,
	output logic                              zero_length
);
	import v3norm_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int QWID = 3*CB + 3 + 2*CB + 2;   // mag, sign, sum

	// front -> queue
	logic                 f_valid, f_ready;
	logic [2:0][CB-1:0]   f_mag;
	logic [2:0]           f_neg;
	logic [2*CB+1:0]      f_sum;

	// queue -> back
	logic                 b_valid, b_ready;
	logic [QWID-1:0]      b_data;
	logic [2:0][CB-1:0]   b_mag;
	logic [2:0]           b_neg;
	logic [2*CB+1:0]      b_sum;

	v3norm_front #(.COORD_BITS(CB)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_x    (start_x),
		.start_y    (start_y),
		.start_z    (start_z),
		.end_x      (end_x),
		.end_y      (end_y),
		.end_z      (end_z),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_mag   (f_mag),
		.push_neg   (f_neg),
		.push_sum   (f_sum)
	);

	v3norm_fifo #(.WIDTH(QWID), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_neg, f_mag, f_sum}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	assign {b_neg, b_mag, b_sum} = b_data;

	v3norm_back #(.COORD_BITS(CB), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (b_valid),
		.in_ready    (b_ready),
		.in_mag      (b_mag),
		.in_neg      (b_neg),
		.in_sum      (b_sum),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.norm_x      (norm_x),
		.norm_y      (norm_y),
		.norm_z      (norm_z),
		.vec_length  (vec_length),
		.zero_length (zero_length)
	);
endmodule

### sv/v3norm_check.sv
// ----------------------------------------------------------------------------
// v3norm_check
// Port-level checks on the normalizer results, bound to the top level.
// ----------------------------------------------------------------------------
module v3norm_check #(
	parameter int COORD_BITS     = v3norm_pkg::COORD_BITS_DEF,
	parameter int UNIT_FRAC_BITS = v3norm_pkg::UNIT_FRAC_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic signed [COORD_BITS-1:0]      start_x,
	input logic signed [COORD_BITS-1:0]      start_y,
	input logic signed [COORD_BITS-1:0]      start_z,
	input logic signed [COORD_BITS-1:0]      end_x,
	input logic signed [COORD_BITS-1:0]      end_y,
	input logic signed [COORD_BITS-1:0]      end_z,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [UNIT_FRAC_BITS+1:0]  norm_x,
	input logic signed [UNIT_FRAC_BITS+1:0]  norm_y,
	input logic signed [UNIT_FRAC_BITS+1:0]  norm_z,
	input logic [COORD_BITS:0]               vec_length,
	input logic                              zero_length
);
	import v3norm_pkg::*;

	localparam logic signed [UNIT_FRAC_BITS+1:0] ONE = {2'b01, {UNIT_FRAC_BITS{1'b0}}};

	// coincident points give an all-zero result
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |->
			norm_x == '0 && norm_y == '0 && norm_z == '0 && vec_length == '0)
		else $error("zero-length result carries nonzero fields");

	// flag and length agree
	a_len_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_length |-> vec_length != '0)
		else $error("nonzero result with zero length");

	// unit components stay within +/- one
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			norm_x <= ONE && norm_x >= -ONE && norm_y <= ONE && norm_y >= -ONE &&
			norm_z <= ONE && norm_z >= -ONE)
		else $error("unit component out of range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(norm_x) && $stable(norm_y) && $stable(norm_z) &&
			$stable(vec_length) && $stable(zero_length))
		else $error("stalled result changed");
endmodule

bind vector3_normalizer_core v3norm_check #(
	.COORD_BITS     (COORD_BITS),
	.UNIT_FRAC_BITS (UNIT_FRAC_BITS)
) u_v3norm_check (.*);

### verif/tb_vector3_normalizer_core.sv
// ----------------------------------------------------------------------------
// tb_vector3_normalizer_core
// Random and directed check of the 3D vector normalizer. Requests are queued
// by an initial block, driven at the falling edge with random gaps, and every
// result is compared field by field with a predicted copy held in order.
// ----------------------------------------------------------------------------
module tb_vector3_normalizer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import v3norm_pkg::*;

	localparam int CB  = COORD_BITS_DEF;
	localparam int UFB = UNIT_FRAC_BITS_DEF;
	localparam int NB  = UFB + 2;
	localparam int LATENCY = 4 + 1 + (CB + 1) + (UFB + 1);
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic signed [CB-1:0] sx, sy, sz, ex, ey, ez;
	} point_pair_t;

	typedef struct packed {
		logic signed [NB-1:0] nx, ny, nz;
		logic [CB:0]          len;
		logic                 zero;
	} unit_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CB-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [NB-1:0] norm_x, norm_y, norm_z;
	logic [CB:0] vec_length;
	logic zero_length;

	point_pair_t pending_reqs[$];
	unit_vec_t   expected_units[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          calm_stretch = 1'b0;
	bit          stim_done = 1'b0;
	bit          accepted_last = 1'b0;

	vector3_normalizer_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.end_x(end_x), .end_y(end_y), .end_z(end_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.vec_length(vec_length), .zero_length(zero_length)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// bitwise floor square root
	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic unit_vec_t normalize_diff(point_pair_t p);
		longint d[3];
		longint unsigned mag, sum, len, q;
		unit_vec_t r;
		logic [NB-1:0] comp[3];
		d[0] = longint'(p.ex) - longint'(p.sx);
		d[1] = longint'(p.ey) - longint'(p.sy);
		d[2] = longint'(p.ez) - longint'(p.sz);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag = d[i] < 0 ? -d[i] : d[i];
			sum += mag * mag;
		end
		len = isqrt(sum);
		r = '0;
		if (len == 0) begin
			r.zero = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			mag = d[i] < 0 ? -d[i] : d[i];
			q = (mag << UFB) / len;
			if (d[i] < 0) q = -q;
			comp[i] = q[NB-1:0];
		end
		r.nx = comp[0];
		r.ny = comp[1];
		r.nz = comp[2];
		r.len = len[CB:0];
		return r;
	endfunction

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			1: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic add_req(input logic [CB-1:0] sx, sy, sz, ex, ey, ez);
		pending_reqs.push_back({sx, sy, sz, ex, ey, ez});
	endtask

	function automatic bit take_gap();
		return !calm_stretch && ($urandom_range(0, 99) < 13);
	endfunction

	// acceptance as seen at the rising edge
	always @(posedge clk) accepted_last <= in_valid && in_ready;

	// driver: valid held with payload until accepted
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accepted_last) begin
				if (pending_reqs.size() != 0 && !take_gap()) begin
					point_pair_t p;
					p = pending_reqs.pop_front();
					{start_x, start_y, start_z, end_x, end_y, end_z} <= p;
					expected_units.push_back(normalize_diff(p));
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !take_gap();
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (out_valid && out_ready) begin
				unit_vec_t got, want;
				got = {norm_x, norm_y, norm_z, vec_length, zero_length};
				if (expected_units.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_units.pop_front();
					if (got !== want) begin
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
		end
	end

	initial begin
		// directed: extremes, zero length, axes, plain vectors
		add_req(0, 0, 0, 0, 0, 0);
		add_req(16'h7fff, 16'h8000, 16'h1234, 16'h7fff, 16'h8000, 16'h1234);
		add_req(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
		add_req(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
		add_req(0, 0, 0, 1, 0, 0);
		add_req(0, 0, 0, 0, 16'hffff, 0);
		add_req(0, 0, 0, 0, 0, 16'h0100);
		add_req(0, 0, 0, 1, 1, 1);
		add_req(0, 0, 0, 16'hffff, 16'hffff, 16'hffff);
		add_req(16'h8000, 0, 0, 16'h7fff, 0, 0);
		add_req(0, 16'h7fff, 0, 0, 16'h8000, 0);
		add_req(0, 0, 0, 3, 4, 0);
		add_req(5, 5, 5, 5, 5, 6);
		add_req(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add_req(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		for (int i = 0; i < 500; i++) begin
			if ($urandom_range(0, 9) == 0)
				add_req(0, 0, 0, rand_coord(), rand_coord(), rand_coord());
			else if ($urandom_range(0, 19) == 0) begin
				logic [CB-1:0] a, b, c;
				a = rand_coord(); b = rand_coord(); c = rand_coord();
				add_req(a, b, c, a, b, c);
			end else
				add_req(rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord());
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// no-gap stretch partway through
		wait (pending_reqs.size() < 300);
		calm_stretch = 1'b1;
		wait (pending_reqs.size() < 200);
		calm_stretch = 1'b0;
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_units.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done || cycle_count >= CYCLE_LIMIT);
		#1;
		if (!stim_done) begin
			$display("Regression FAIL");
		end else if (mismatch_count == 0 && expected_units.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

### vector3_normalizer_core.f
sv/v3norm_pkg.sv
sv/v3norm_front.sv
sv/v3norm_fifo.sv
sv/v3norm_back.sv
sv/vector3_normalizer_core.sv
sv/v3norm_check.sv
verif/tb_vector3_normalizer_core.sv
